/* sv/bsc_pkg.sv */
package bsc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CovW   = 17;
  localparam int unsigned NdcW   = 18;
  localparam logic [CovW-1:0] NdcOne = 17'd65536;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROW_X_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_X_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_Y_FIRST  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROW_Y_SECOND = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ROW_W_FIRST  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ROW_W_SECOND = 3'd5;

  // outcome codes
  localparam logic [1:0] OUT_PROJECTED = 2'd0;
  localparam logic [1:0] OUT_INVALID   = 2'd1;
  localparam logic [1:0] OUT_BEHIND    = 2'd2;
  localparam logic [1:0] OUT_STRADDLE  = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] box_min_x;
    logic signed [CoordW-1:0] box_min_y;
    logic signed [CoordW-1:0] box_min_z;
    logic signed [CoordW-1:0] box_max_x;
    logic signed [CoordW-1:0] box_max_y;
    logic signed [CoordW-1:0] box_max_z;
  } in_item_t;

  typedef struct packed {
    logic [CovW-1:0] coverage;
    logic [1:0]      outcome;
  } out_item_t;

endpackage

/* sv/box_screen_coverage_unit.sv */
// box screen coverage unit
// in channel: one box per item (min/max corners, signed fixed point with
// FRAC_BITS fraction bits). out channel: one coverage/outcome item per box.
// cfg channel: 64-bit writes to the six matrix row registers, always ready;
// write them only while no box is in flight.
// the box is held in an input register and its 8 corners are issued one per
// cycle unless the receiver stalls, into a shared corner pipeline: 9 multipliers,
// row sums, sign/saturate prep, an 8-stage divider retiring 2 quotient bits per
// stage for x and y, then a min/max accumulator, the area multiplier and the
// output register; the single corner pipeline sets the box throughput.
// reset clears all valid bits and loads the identity-like matrix defaults.
// when the receiver stalls the whole pipeline holds; the input register takes
// a new box only as its last corner is issued, so nothing is lost.
module box_screen_coverage_unit
  import bsc_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  localparam int unsigned SW = 66 - FRAC_BITS;          // clip sum width
  localparam int unsigned NDS = 8;                      // divider stages
  localparam logic signed [SW-1:0] WEps = SW'((64'd1 << FRAC_BITS) / 64'd100000);
  localparam logic [CfgW-1:0] OneLo = CfgW'(64'd1 << FRAC_BITS);
  localparam logic [CfgW-1:0] OneHi = CfgW'(64'd1 << (32 + FRAC_BITS));

  // configuration
  logic [CfgW-1:0] rxa_q, rxb_q, rya_q, ryb_q, rwa_q, rwb_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rxa_q <= OneLo;
      rxb_q <= '0;
      rya_q <= OneHi;
      ryb_q <= '0;
      rwa_q <= '0;
      rwb_q <= OneHi;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROW_X_FIRST:  rxa_q <= cfg_data_i;
        CFG_ROW_X_SECOND: rxb_q <= cfg_data_i;
        CFG_ROW_Y_FIRST:  rya_q <= cfg_data_i;
        CFG_ROW_Y_SECOND: ryb_q <= cfg_data_i;
        CFG_ROW_W_FIRST:  rwa_q <= cfg_data_i;
        CFG_ROW_W_SECOND: rwb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  out_item_t out_q;
  assign en = !out_valid_q || out_ready_i;

  // input register and corner issue
  logic busy_q;
  logic [2:0] cnt_q;
  in_item_t box_q;
  logic inv_q;
  logic in_acc;

  assign in_ready_o = !busy_q || (en && cnt_q == 3'd7);
  assign in_acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q && en) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd7) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      box_q <= in_item_i;
      inv_q <= (in_item_i.box_min_x > in_item_i.box_max_x) ||
               (in_item_i.box_min_y > in_item_i.box_max_y) ||
               (in_item_i.box_min_z > in_item_i.box_max_z);
    end
  end

  // stage 1: corner coordinates
  logic s1_v_q, s1_inv_q, s1_first_q, s1_last_q;
  logic signed [CoordW-1:0] s1_c_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en) s1_v_q <= busy_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_inv_q   <= inv_q;
      s1_first_q <= cnt_q == 3'd0;
      s1_last_q  <= cnt_q == 3'd7;
      s1_c_q[0]  <= cnt_q[0] ? box_q.box_max_x : box_q.box_min_x;
      s1_c_q[1]  <= cnt_q[1] ? box_q.box_max_y : box_q.box_min_y;
      s1_c_q[2]  <= cnt_q[2] ? box_q.box_max_z : box_q.box_min_z;
    end
  end

  // stage 2: nine products, row r column k
  logic s2_v_q, s2_inv_q, s2_first_q, s2_last_q;
  logic signed [63:0] s2_p_q [3][3];
  logic signed [31:0] ent [3][3];
  logic signed [31:0] wcol [3];

  always_comb begin
    ent[0][0] = rxa_q[31:0]; ent[0][1] = rxa_q[63:32]; ent[0][2] = rxb_q[31:0];
    ent[1][0] = rya_q[31:0]; ent[1][1] = rya_q[63:32]; ent[1][2] = ryb_q[31:0];
    ent[2][0] = rwa_q[31:0]; ent[2][1] = rwa_q[63:32]; ent[2][2] = rwb_q[31:0];
    wcol[0] = rxb_q[63:32];
    wcol[1] = ryb_q[63:32];
    wcol[2] = rwb_q[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_inv_q   <= s1_inv_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          s2_p_q[r][k] <= 64'(ent[r][k]) * 64'(s1_c_q[k]);
        end
      end
    end
  end

  // stage 3: floored products plus w column
  logic s3_v_q, s3_inv_q, s3_first_q, s3_last_q;
  logic signed [SW-1:0] s3_s_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_inv_q   <= s2_inv_q;
      s3_first_q <= s2_first_q;
      s3_last_q  <= s2_last_q;
      for (int r = 0; r < 3; r++) begin
        s3_s_q[r] <= SW'(wcol[r]) + SW'(s2_p_q[r][0] >>> FRAC_BITS) +
                     SW'(s2_p_q[r][1] >>> FRAC_BITS) + SW'(s2_p_q[r][2] >>> FRAC_BITS);
      end
    end
  end

  // stage 4: front test, magnitudes, saturation
  logic s4_v_q, s4_inv_q, s4_first_q, s4_last_q, s4_front_q;
  logic [1:0] s4_neg_q, s4_sat_q;
  logic [SW-1:0] s4_mag_q [2];
  logic [SW-1:0] s4_w_q;
  logic [SW-1:0] mag [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mag[a] = s3_s_q[a][SW-1] ? SW'(-s3_s_q[a]) : s3_s_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_inv_q   <= s3_inv_q;
      s4_first_q <= s3_first_q;
      s4_last_q  <= s3_last_q;
      s4_front_q <= s3_s_q[2] > WEps;
      s4_w_q     <= s3_s_q[2];
      for (int a = 0; a < 2; a++) begin
        s4_neg_q[a] <= s3_s_q[a][SW-1];
        s4_sat_q[a] <= mag[a] >= s3_s_q[2];
        s4_mag_q[a] <= mag[a];
      end
    end
  end

  // divider: two restoring steps per stage for x and y
  logic          dv_v_q [NDS];
  logic          dv_inv_q [NDS], dv_first_q [NDS], dv_last_q [NDS], dv_front_q [NDS];
  logic [1:0]    dv_neg_q [NDS], dv_sat_q [NDS];
  logic [SW-1:0] dv_w_q [NDS];
  logic [SW:0]   dv_r_q [NDS][2];
  logic [15:0]   dv_qt_q [NDS][2];
  logic [SW:0]   r_in [NDS][2];
  logic [15:0]   q_in [NDS][2];
  logic [SW-1:0] w_in [NDS];
  logic [SW:0]   r_nx [NDS][2];
  logic [15:0]   q_nx [NDS][2];
  logic [SW:0]   rt;

  always_comb begin
    rt = '0;
    for (int j = 0; j < NDS; j++) begin
      w_in[j] = (j == 0) ? s4_w_q : dv_w_q[(j == 0) ? 0 : j - 1];
      for (int a = 0; a < 2; a++) begin
        r_in[j][a] = (j == 0) ? {1'b0, s4_mag_q[a]} : dv_r_q[(j == 0) ? 0 : j - 1][a];
        q_in[j][a] = (j == 0) ? 16'd0 : dv_qt_q[(j == 0) ? 0 : j - 1][a];
        rt = r_in[j][a];
        q_nx[j][a] = q_in[j][a];
        for (int s = 0; s < 2; s++) begin
          rt = {rt[SW-1:0], 1'b0};
          q_nx[j][a] = {q_nx[j][a][14:0], 1'b0};
          if (rt >= {1'b0, w_in[j]}) begin
            rt = rt - {1'b0, w_in[j]};
            q_nx[j][a][0] = 1'b1;
          end
        end
        r_nx[j][a] = rt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NDS; j++) dv_v_q[j] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= s4_v_q;
      for (int j = 1; j < NDS; j++) dv_v_q[j] <= dv_v_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_inv_q[0]   <= s4_inv_q;
      dv_first_q[0] <= s4_first_q;
      dv_last_q[0]  <= s4_last_q;
      dv_front_q[0] <= s4_front_q;
      dv_neg_q[0]   <= s4_neg_q;
      dv_sat_q[0]   <= s4_sat_q;
      for (int j = 1; j < NDS; j++) begin
        dv_inv_q[j]   <= dv_inv_q[j-1];
        dv_first_q[j] <= dv_first_q[j-1];
        dv_last_q[j]  <= dv_last_q[j-1];
        dv_front_q[j] <= dv_front_q[j-1];
        dv_neg_q[j]   <= dv_neg_q[j-1];
        dv_sat_q[j]   <= dv_sat_q[j-1];
      end
      for (int j = 0; j < NDS; j++) begin
        dv_w_q[j] <= w_in[j];
        for (int a = 0; a < 2; a++) begin
          dv_r_q[j][a]  <= r_nx[j][a];
          dv_qt_q[j][a] <= q_nx[j][a];
        end
      end
    end
  end

  // stage 5: signed ndc values
  logic s5_v_q, s5_inv_q, s5_first_q, s5_last_q, s5_front_q;
  logic signed [NdcW-1:0] s5_n_q [2];
  logic signed [NdcW-1:0] mag_n [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mag_n[a] = dv_sat_q[NDS-1][a] ? NdcW'(NdcOne) : NdcW'(dv_qt_q[NDS-1][a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en) s5_v_q <= dv_v_q[NDS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_inv_q   <= dv_inv_q[NDS-1];
      s5_first_q <= dv_first_q[NDS-1];
      s5_last_q  <= dv_last_q[NDS-1];
      s5_front_q <= dv_front_q[NDS-1];
      for (int a = 0; a < 2; a++) begin
        s5_n_q[a] <= dv_neg_q[NDS-1][a] ? -mag_n[a] : mag_n[a];
      end
    end
  end

  // accumulate bounds over the eight corners of one box
  logic signed [NdcW-1:0] lo_q [2], hi_q [2], lo_d [2], hi_d [2];
  logic all_q, any_q, all_d, any_d;
  logic fin_v_q, fin_inv_q, fin_all_q, fin_any_q;
  logic signed [NdcW-1:0] fin_lo_q [2], fin_hi_q [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (s5_first_q) begin
        lo_d[a] = s5_n_q[a];
        hi_d[a] = s5_n_q[a];
      end else begin
        lo_d[a] = (s5_n_q[a] < lo_q[a]) ? s5_n_q[a] : lo_q[a];
        hi_d[a] = (s5_n_q[a] > hi_q[a]) ? s5_n_q[a] : hi_q[a];
      end
    end
    all_d = s5_front_q && (s5_first_q || all_q);
    any_d = s5_front_q || (!s5_first_q && any_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fin_v_q <= 1'b0;
    else if (en) fin_v_q <= s5_v_q && s5_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (en && s5_v_q) begin
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      all_q     <= all_d;
      any_q     <= any_d;
      fin_lo_q  <= lo_d;
      fin_hi_q  <= hi_d;
      fin_inv_q <= s5_inv_q;
      fin_all_q <= all_d;
      fin_any_q <= any_d;
    end
  end

  // area product and outcome
  logic mul_v_q;
  logic [1:0] mul_oc_q;
  logic [2*NdcW-1:0] mul_p_q;
  logic [NdcW-1:0] dx, dy;
  logic [1:0] oc;

  assign dx = NdcW'(fin_hi_q[0] - fin_lo_q[0]);
  assign dy = NdcW'(fin_hi_q[1] - fin_lo_q[1]);

  always_comb begin
    if (fin_inv_q) oc = OUT_INVALID;
    else if (!fin_any_q) oc = OUT_BEHIND;
    else if (!fin_all_q) oc = OUT_STRADDLE;
    else oc = OUT_PROJECTED;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mul_v_q <= 1'b0;
    else if (en) mul_v_q <= fin_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_oc_q <= oc;
      mul_p_q  <= dx * dy;
    end
  end

  // output register
  logic [2*NdcW-19:0] area;
  out_item_t out_d;

  assign area = mul_p_q[2*NdcW-1:18];

  always_comb begin
    out_d.outcome = mul_oc_q;
    case (mul_oc_q)
      OUT_PROJECTED: out_d.coverage = (area > (2*NdcW-18)'(NdcOne)) ? NdcOne : CovW'(area);
      OUT_STRADDLE:  out_d.coverage = NdcOne;
      default:       out_d.coverage = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= mul_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.coverage <= NdcOne)
    else $error("coverage above full screen");

  a_cov_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.outcome == OUT_INVALID || out_item_o.outcome == OUT_BEHIND)
    |-> out_item_o.coverage == '0)
    else $error("culled box with nonzero coverage");

  a_straddle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.outcome == OUT_STRADDLE |-> out_item_o.coverage == NdcOne)
    else $error("straddling box without full coverage");

  a_issue_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> busy_q && cnt_q == 3'd0)
    else $error("corner issue did not restart");

  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != 3'd7 |-> !in_ready_o)
    else $error("input taken while corners pending");

endmodule

/* tb/sv/tb_box_screen_coverage_unit.sv */
`timescale 1ns / 100ps

module tb_box_screen_coverage_unit;
  import bsc_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam longint WEps = (longint'(1) << FracBits) / 100000;
  localparam int unsigned Latency = 23;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;

  box_screen_coverage_unit #(.FRAC_BITS(FracBits)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // local copy of the matrix rows
  logic [CfgW-1:0] matrix_q [6];
  out_item_t coverage_q [$];
  int unsigned n_errors;
  int unsigned n_boxes;
  int unsigned n_results;
  int unsigned n_by_outcome [4];
  int unsigned hold_cycles;
  bit          rand_stall;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint floor_shr(longint v);
    return v >>> FracBits;
  endfunction

  function automatic longint row_sum(logic [CfgW-1:0] first, logic [CfgW-1:0] second,
                                     longint px, longint py, longint pz);
    longint s;
    s = longint'($signed(second[63:32]));
    s += floor_shr(longint'($signed(first[31:0])) * px);
    s += floor_shr(longint'($signed(first[63:32])) * py);
    s += floor_shr(longint'($signed(second[31:0])) * pz);
    return s;
  endfunction

  function automatic int ndc_div(longint num, longint w);
    logic [63:0] mag, r, q;
    mag = num < 0 ? -num : num;
    if (mag >= w) return num < 0 ? -65536 : 65536;
    r = mag;
    q = 0;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= w) begin
        r -= w;
        q[0] = 1'b1;
      end
    end
    return num < 0 ? -int'(q) : int'(q);
  endfunction

  function automatic out_item_t predict_coverage(in_item_t b);
    out_item_t res;
    longint lo [3], hi [3], cx [8], cy [8], cw [8];
    longint px, py, pz;
    int front, nx, ny, minx, maxx, miny, maxy;
    logic [63:0] area;
    lo[0] = b.box_min_x; lo[1] = b.box_min_y; lo[2] = b.box_min_z;
    hi[0] = b.box_max_x; hi[1] = b.box_max_y; hi[2] = b.box_max_z;
    res = '0;
    if (lo[0] > hi[0] || lo[1] > hi[1] || lo[2] > hi[2]) begin
      res.outcome = OUT_INVALID;
      return res;
    end
    front = 0;
    for (int i = 0; i < 8; i++) begin
      px = i[0] ? hi[0] : lo[0];
      py = i[1] ? hi[1] : lo[1];
      pz = i[2] ? hi[2] : lo[2];
      cx[i] = row_sum(matrix_q[CFG_ROW_X_FIRST], matrix_q[CFG_ROW_X_SECOND], px, py, pz);
      cy[i] = row_sum(matrix_q[CFG_ROW_Y_FIRST], matrix_q[CFG_ROW_Y_SECOND], px, py, pz);
      cw[i] = row_sum(matrix_q[CFG_ROW_W_FIRST], matrix_q[CFG_ROW_W_SECOND], px, py, pz);
      if (cw[i] > WEps) front++;
    end
    if (front == 0) begin
      res.outcome = OUT_BEHIND;
      return res;
    end
    if (front < 8) begin
      res.coverage = NdcOne;
      res.outcome = OUT_STRADDLE;
      return res;
    end
    minx = 65536; maxx = -65536; miny = 65536; maxy = -65536;
    for (int i = 0; i < 8; i++) begin
      nx = ndc_div(cx[i], cw[i]);
      ny = ndc_div(cy[i], cw[i]);
      if (nx < minx) minx = nx;
      if (nx > maxx) maxx = nx;
      if (ny < miny) miny = ny;
      if (ny > maxy) maxy = ny;
    end
    area = (64'(maxx - minx) * 64'(maxy - miny)) >> 18;
    if (area > 65536) area = 65536;
    res.coverage = area[CovW-1:0];
    res.outcome = OUT_PROJECTED;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // result checker and receiver stall control
  always @(posedge clk_i) begin
    out_item_t want;
    if (out_valid_o && out_ready_i) begin
      n_results++;
      if (coverage_q.size() == 0) begin
        report_mismatch("unexpected item outcome", out_item_o.outcome, -1);
      end else begin
        want = coverage_q.pop_front();
        n_by_outcome[want.outcome]++;
        if (out_item_o.coverage !== want.coverage)
          report_mismatch("coverage", out_item_o.coverage, want.coverage);
        if (out_item_o.outcome !== want.outcome)
          report_mismatch("outcome", out_item_o.outcome, want.outcome);
      end
    end
  end

  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      gap = rand_stall ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      // one wait draw per item
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_box(in_item_t b, bit pace);
    int gap;
    gap = pace ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= b;
    coverage_q.push_back(predict_coverage(b));
    n_boxes++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (coverage_q.size() > 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_matrix(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    matrix_q[idx] = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] q16(int whole);
    return 32'(whole) << FracBits;
  endfunction

  function automatic in_item_t make_box(int x0, int y0, int z0, int x1, int y1, int z1);
    in_item_t b;
    b.box_min_x = x0; b.box_min_y = y0; b.box_min_z = z0;
    b.box_max_x = x1; b.box_max_y = y1; b.box_max_z = z1;
    return b;
  endfunction

  // random box: mostly small ordered coordinates, sometimes raw bits
  function automatic in_item_t random_box();
    int lo, hi, a, c, sp;
    int v [6];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 9))
        0: begin a = $urandom(); c = $urandom(); end
        1: begin a = $urandom_range(0, 4) << 16; c = a; end
        default: begin
          sp = $urandom_range(8, 22);
          a = $signed($urandom_range(0, (1 << sp) - 1)) - (1 << (sp - 1));
          c = a + $urandom_range(0, (1 << sp) - 1);
        end
      endcase
      if ($urandom_range(0, 19) != 0 && a > c) begin
        lo = c; hi = a; a = lo; c = hi;
      end
      v[k] = a; v[k + 3] = c;
    end
    return make_box(v[0], v[1], v[2], v[3], v[4], v[5]);
  endfunction

  // perspective-like matrix: w depends on z, with a random camera offset
  task automatic load_random_matrix();
    logic [31:0] e [12];
    for (int k = 0; k < 12; k++)
      e[k] = $urandom_range(0, 3) == 0 ? $urandom() : $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    e[0] = $urandom_range(1 << 14, 1 << 18);
    e[5] = $urandom_range(1 << 14, 1 << 18);
    e[10] = $urandom_range(1 << 15, 1 << 17);
    e[11] = $signed($urandom_range(0, 1 << 22)) - (1 << 20);
    for (int r = 0; r < 3; r++) begin
      write_matrix(3'(2 * r), {e[4 * r + 1], e[4 * r]});
      write_matrix(3'(2 * r + 1), {e[4 * r + 3], e[4 * r + 2]});
    end
  endtask

  task automatic load_default_matrix();
    write_matrix(CFG_ROW_X_FIRST, {32'd0, q16(1)});
    write_matrix(CFG_ROW_X_SECOND, '0);
    write_matrix(CFG_ROW_Y_FIRST, {q16(1), 32'd0});
    write_matrix(CFG_ROW_Y_SECOND, '0);
    write_matrix(CFG_ROW_W_FIRST, '0);
    write_matrix(CFG_ROW_W_SECOND, {q16(1), 32'd0});
  endtask

  task automatic test_directed();
    // reset matrix: w = 1 everywhere, ndc = x, y
    send_box(make_box(-q16(1), -q16(1), 0, q16(1), q16(1), 0), 0);
    send_box(make_box(0, 0, 0, 32'h4000, 32'h8000, 0), 0);
    send_box(make_box(5, 0, 0, 4, 0, 0), 0);
    send_box(make_box(0, 5, 0, 0, 4, 0), 0);
    send_box(make_box(0, 0, 5, 0, 0, 4), 0);
    send_box(make_box(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0);
    send_box(make_box(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0);
    send_box(make_box(32'h80000000, 32'h80000000, 0, 32'h80000000, 32'h80000000, 0), 0);
    send_box(make_box(32'hffffffff, 0, 0, 32'hfffffffe, 0, 0), 0);
    drain();
    // w = z: behind, straddling, in front, and at the epsilon edge
    write_matrix(CFG_ROW_W_SECOND, {32'd0, q16(1)});
    send_box(make_box(0, 0, -q16(4), q16(1), q16(1), -q16(1)), 0);
    send_box(make_box(0, 0, -q16(1), q16(1), q16(1), q16(1)), 0);
    send_box(make_box(-q16(1), -q16(1), q16(2), q16(1), q16(1), q16(4)), 0);
    send_box(make_box(0, 0, 32'(WEps), 1, 1, 32'(WEps)), 0);
    send_box(make_box(0, 0, 32'(WEps + 1), 1, 1, 32'(WEps + 1)), 0);
    send_box(make_box(-q16(100), 3, 1, q16(100), 7, 1), 0);
    send_box(make_box(32'h80000000, 32'h80000000, 32'h7fffffff,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0);
    drain();
    // matrix extremes in every entry
    for (int idx = 0; idx < 6; idx++) write_matrix(3'(idx), 64'h8000_0000_7fff_ffff);
    send_box(make_box(-q16(1), -q16(2), -q16(3), q16(1), q16(2), q16(3)), 0);
    send_box(make_box(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 0);
    drain();
    for (int idx = 0; idx < 6; idx++) write_matrix(3'(idx), 64'h7fff_ffff_8000_0000);
    send_box(make_box(-q16(1), -q16(2), -q16(3), q16(1), q16(2), q16(3)), 0);
    send_box(make_box(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000), 0);
    drain();
    for (int idx = 0; idx < 6; idx++) write_matrix(3'(idx), '1);
    send_box(make_box(1, 1, 1, 1, 1, 1), 0);
    drain();
    load_default_matrix();
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 10; phase++) begin
      load_random_matrix();
      rand_stall = phase % 3 != 2;
      for (int i = 0; i < 150; i++) send_box(random_box(), phase % 3 != 1);
      drain();
    end
  endtask

  task automatic test_backpressure();
    rand_stall = 1'b0;
    hold_cycles = 200;
    for (int i = 0; i < 60; i++) send_box(random_box(), 0);
    // sender waits for every result before going on
    drain();
    for (int i = 0; i < 40; i++) send_box(random_box(), 1);
    drain();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    rand_stall = 1'b1;
    hold_cycles = 0;
    n_errors = 0;
    n_boxes = 0;
    n_results = 0;
    matrix_q[0] = 64'd65536;
    matrix_q[1] = '0;
    matrix_q[2] = 64'd65536 << 32;
    matrix_q[3] = '0;
    matrix_q[4] = '0;
    matrix_q[5] = 64'd65536 << 32;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phases();
    test_backpressure();
    load_default_matrix();
    for (int i = 0; i < 100; i++) send_box(random_box(), 1);
    drain();
    $display("boxes %0d results %0d over fixed and random matrices with stalls and a long hold",
             n_boxes, n_results);
    $display("outcomes: projected %0d invalid %0d behind %0d straddle %0d",
             n_by_outcome[0], n_by_outcome[1], n_by_outcome[2], n_by_outcome[3]);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
